### rtl/mpfe_pkg.sv
// Shared types, constants and helpers for the page-layout framebuffer engine.
package mpfe_pkg;

  localparam int COLUMNS    = 128;
  localparam int ROWS       = 32;
  localparam int PAGES      = (ROWS + 7) / 8;
  localparam int STORE_SIZE = COLUMNS * PAGES;
  localparam int SEQ_CMDS   = 3;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int ADDR_W = $clog2(STORE_SIZE);
  localparam int IDX_W  = $clog2(COLUMNS + SEQ_CMDS);

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h04;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  localparam logic [2:0] OP_POINT   = 3'd0;
  localparam logic [2:0] OP_FILL    = 3'd1;
  localparam logic [2:0] OP_PATTERN = 3'd2;
  localparam logic [2:0] OP_CLEAR   = 3'd3;
  localparam logic [2:0] OP_REFRESH = 3'd4;
  localparam logic [2:0] OP_RBYTE   = 3'd5;

  localparam logic [1:0] MODE_FILL = 2'd0;
  localparam logic [1:0] MODE_HPAT = 2'd1;
  localparam logic [1:0] MODE_VPAT = 2'd2;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] x_end;
    logic [7:0] y_end;
    logic       value;
    logic [7:0] pattern;
    logic [3:0] bit_count;
    logic       vertical;
    logic       invert;
    logic       force_req;
  } in_item_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] byte_value;
    logic       frame_end;
  } out_item_t;

  // Clipped byte span of one drawing item.
  typedef struct packed {
    logic              empty;
    logic [COL_W-1:0]  x_first;
    logic [COL_W-1:0]  x_last;
    logic [2:0]        x_lo;
    logic [PAGE_W-1:0] pg_first;
    logic [PAGE_W-1:0] pg_last;
    logic [2:0]        row_lo;
    logic [2:0]        row_hi;
    logic [1:0]        mode;
    logic              val;
    logic [15:0]       pat;
  } span_t;

  // Refresh sequencer status toward the datapath.
  typedef struct packed {
    logic              active;
    logic              is_data;
    logic              last;
    logic [7:0]        cmd_byte;
    logic [ADDR_W-1:0] addr;
  } rfs_t;

  function automatic logic [ADDR_W-1:0] store_addr(input logic [COL_W-1:0] col,
                                                   input logic [PAGE_W-1:0] pg);
    return ADDR_W'(ADDR_W'(col) * ADDR_W'(PAGES) + ADDR_W'(pg));
  endfunction

endpackage

### rtl/mpfe_ram.sv
// Generic simple dual-port RAM with registered read.
module mpfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/mpfe_span.sv
// Drawing item decode: corner ordering, clipping and byte span of the item.
module mpfe_span (
  input  mpfe_pkg::in_item_t item,
  output mpfe_pkg::span_t    span
);
  import mpfe_pkg::*;

  always_comb begin
    logic [3:0] n;
    logic [8:0] x0, x1, y0, y1, x1c, y1c;
    logic [7:0] rev;
    n   = (item.bit_count == 4'd0) ? 4'd1 : ((item.bit_count > 4'd8) ? 4'd8 : item.bit_count);
    x0  = {1'b0, item.x};
    x1  = {1'b0, item.x};
    y0  = {1'b0, item.y};
    y1  = {1'b0, item.y};
    for (int k = 0; k < 8; k++) begin
      rev[k] = item.pattern[7-k] ^ item.invert;
    end
    span.mode = MODE_FILL;
    span.pat  = 16'd0;
    unique case (item.opcode)
      OP_FILL: begin
        // swap reversed corners
        if (item.x > item.x_end) begin
          x0 = {1'b0, item.x_end};
        end else begin
          x1 = {1'b0, item.x_end};
        end
        if (item.y > item.y_end) begin
          y0 = {1'b0, item.y_end};
        end else begin
          y1 = {1'b0, item.y_end};
        end
      end
      OP_PATTERN: begin
        if (item.vertical) begin
          y1        = 9'({1'b0, item.y} + 9'(n) - 9'd1);
          span.mode = MODE_VPAT;
          span.pat  = 16'({8'd0, item.pattern ^ {8{item.invert}}} << item.y[2:0]);
        end else begin
          x1        = 9'({1'b0, item.x} + 9'(n) - 9'd1);
          span.mode = MODE_HPAT;
          span.pat  = {8'd0, rev};
        end
      end
      default: begin
      end
    endcase
    x1c = (x1 >= 9'(COLUMNS)) ? 9'(COLUMNS - 1) : x1;
    y1c = (y1 >= 9'(ROWS)) ? 9'(ROWS - 1) : y1;
    span.empty    = (x0 >= 9'(COLUMNS)) || (y0 >= 9'(ROWS));
    span.x_first  = COL_W'(x0);
    span.x_last   = COL_W'(x1c);
    span.x_lo     = x0[2:0];
    span.pg_first = PAGE_W'(y0 >> 3);
    span.pg_last  = PAGE_W'(y1c >> 3);
    span.row_lo   = y0[2:0];
    span.row_hi   = y1c[2:0];
    span.val      = item.value;
  end

endmodule

### rtl/mpfe_refresh.sv
// Refresh sequencer: page and byte position, command bytes and data addresses.
module mpfe_refresh (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           advance,
  input  logic           flip,
  output mpfe_pkg::rfs_t rfs
);
  import mpfe_pkg::*;

  logic              active_r, active_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [COL_W-1:0]  col;
  logic              page_end;

  assign page_end = (idx_r == IDX_W'(COLUMNS + SEQ_CMDS - 1));

  always_comb begin
    col = COL_W'(idx_r - IDX_W'(SEQ_CMDS));
    if (flip) begin
      col = COL_W'(COLUMNS - 1) - col;
    end
    rfs.active  = active_r;
    rfs.is_data = (idx_r >= IDX_W'(SEQ_CMDS));
    rfs.last    = page_end && (page_r == PAGE_W'(PAGES - 1));
    rfs.addr    = store_addr(col, page_r);
    priority if (idx_r == IDX_W'(0)) begin
      rfs.cmd_byte = 8'(CMD_PAGE_BASE + 8'(page_r));
    end else if (idx_r == IDX_W'(1)) begin
      rfs.cmd_byte = CMD_COL_LOW;
    end else begin
      rfs.cmd_byte = CMD_COL_HIGH;
    end
  end

  always_comb begin
    active_nxt = active_r;
    page_nxt   = page_r;
    idx_nxt    = idx_r;
    priority if (start) begin
      active_nxt = 1'b1;
      page_nxt   = '0;
      idx_nxt    = '0;
    end else if (advance) begin
      idx_nxt = idx_r + IDX_W'(1);
      if (page_end) begin
        idx_nxt = '0;
        if (page_r == PAGE_W'(PAGES - 1)) begin
          page_nxt   = '0;
          active_nxt = 1'b0;
        end else begin
          page_nxt = page_r + PAGE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      page_r   <= '0;
      idx_r    <= '0;
    end else begin
      active_r <= active_nxt;
      page_r   <= page_nxt;
      idx_r    <= idx_nxt;
    end
  end

endmodule

### rtl/mono_page_framebuffer_engine.sv
// Top level of the monochrome page-layout framebuffer engine.
// The 128x32 picture lives in a 512-byte RAM, one byte per column and 8-row page,
// bit 0 at the top of the page. After reset, and after every clear item, the engine
// zeroes the RAM one byte per cycle and takes no items meanwhile; flip writes are
// taken at any time. A draw item reads its first RAM byte when taken and then writes
// its bytes in the write state; a refresh byte reads its RAM byte when taken and
// then loads the output register in the emit state. A refresh start, an undefined
// opcode, a draw wholly off screen and a refresh byte while no refresh runs leave the
// engine idle. Every touched byte is a read-modify-write through the single write
// port, with the read of the next byte overlapped with the write of the current one.
// A refresh byte also waits until the output register is free. Refresh bytes read
// the RAM live, so drawing between them shows up in the bytes not yet sent;
// frame_end marks the last data byte of page 3.
module mono_page_framebuffer_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mpfe_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mpfe_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);
  import mpfe_pkg::*;

  localparam logic [1:0] S_SWEEP = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_WR    = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] sweep_r, sweep_nxt;
  logic [COL_W-1:0]  cx_r, cx_nxt;
  logic [PAGE_W-1:0] pg_r, pg_nxt;
  span_t             span, span_r;
  logic              dirty_r, dirty_nxt;
  logic              flip_r;
  logic              out_valid_r;
  out_item_t         out_data_r;
  rfs_t              rfs;

  logic              in_fire, is_draw, rfs_start, rb_go, out_load, wk_last;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;
  logic [7:0]        mask, data;
  logic [2:0]        row_lo, row_hi, hk;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign is_draw   = (in_data.opcode == OP_POINT) || (in_data.opcode == OP_FILL) ||
                     (in_data.opcode == OP_PATTERN);
  assign rfs_start = in_fire && ((in_data.opcode == OP_CLEAR) ||
                     ((in_data.opcode == OP_REFRESH) && (in_data.force_req || dirty_r)));
  assign rb_go     = in_fire && (in_data.opcode == OP_RBYTE) && rfs.active;
  assign out_load  = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  mpfe_span u_span (
    .item (in_data),
    .span (span)
  );

  mpfe_refresh u_refresh (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (rfs_start),
    .advance (out_load),
    .flip    (flip_r),
    .rfs     (rfs)
  );

  mpfe_ram #(
    .WIDTH (8),
    .DEPTH (STORE_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // byte walk: pages inner, columns outer
  assign wk_last = (cx_r == span_r.x_last) && (pg_r == span_r.pg_last);

  always_comb begin
    if (pg_r == span_r.pg_last) begin
      cx_nxt = cx_r + COL_W'(1);
      pg_nxt = span_r.pg_first;
    end else begin
      cx_nxt = cx_r;
      pg_nxt = pg_r + PAGE_W'(1);
    end
  end

  // rows of the current page covered by the span
  assign row_lo = (pg_r == span_r.pg_first) ? span_r.row_lo : 3'd0;
  assign row_hi = (pg_r == span_r.pg_last) ? span_r.row_hi : 3'd7;
  assign mask   = (8'hFF << row_lo) & (8'hFF >> (3'd7 - row_hi));
  assign hk     = cx_r[2:0] - span_r.x_lo;

  always_comb begin
    unique case (span_r.mode)
      MODE_FILL: data = {8{span_r.val}};
      MODE_HPAT: data = {8{span_r.pat[hk]}};
      MODE_VPAT: data = (pg_r == span_r.pg_first) ? span_r.pat[7:0] : span_r.pat[15:8];
      default:   data = 8'd0;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = store_addr(cx_r, pg_r);
    ram_wdata = (ram_rdata & ~mask) | (data & mask);
    ram_re    = 1'b0;
    ram_raddr = store_addr(cx_nxt, pg_nxt);
    unique case (state_r)
      S_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_r;
        ram_wdata = 8'd0;
      end
      S_IDLE: begin
        ram_re    = in_fire;
        ram_raddr = (in_data.opcode == OP_RBYTE) ? rfs.addr :
                    store_addr(span.x_first, span.pg_first);
      end
      S_WR: begin
        ram_we = 1'b1;
        ram_re = !wk_last;
      end
      S_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    sweep_nxt = sweep_r + ADDR_W'(1);
    dirty_nxt = dirty_r;
    if (rfs_start) begin
      dirty_nxt = 1'b0;
    end else if (state_r == S_WR) begin
      dirty_nxt = 1'b1;
    end
    unique case (state_r)
      S_SWEEP: begin
        if (sweep_r == ADDR_W'(STORE_SIZE - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        sweep_nxt = '0;
        if (in_fire) begin
          priority if (in_data.opcode == OP_CLEAR) begin
            state_nxt = S_SWEEP;
          end else if (is_draw && !span.empty) begin
            state_nxt = S_WR;
          end else if (rb_go) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_WR: begin
        if (wk_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      sweep_r     <= '0;
      dirty_r     <= 1'b0;
      flip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      dirty_r <= dirty_nxt;
      if (cfg_valid && cfg_ready) begin
        flip_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      span_r <= span;
      cx_r   <= span.x_first;
      pg_r   <= span.pg_first;
    end else if (state_r == S_WR) begin
      cx_r <= cx_nxt;
      pg_r <= pg_nxt;
    end
    if (out_load) begin
      out_data_r.is_data    <= rfs.is_data;
      out_data_r.byte_value <= rfs.is_data ? ram_rdata : rfs.cmd_byte;
      out_data_r.frame_end  <= rfs.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // walk stays inside its clipped column range
  a_walk_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |-> (cx_r <= span_r.x_last))
    else $error("walk column beyond span end");

  // overlapped read never hits the byte being written
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR && ram_re) |-> (ram_raddr != ram_waddr))
    else $error("read and write of the same byte in one cycle");

  // a new beat only comes out of the emit state
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_EMIT))
    else $error("result beat without an emit");

  // the frame-end beat closes the refresh
  a_frame_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(out_load) && out_data_r.frame_end) |-> !rfs.active)
    else $error("refresh still active after frame end");

endmodule
